FILE: rtl/mbhw_pkg.sv
package mbhw_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 48;
    localparam int unsigned HLEN_W   = 5;
    localparam int unsigned TYPE_W   = 32;
    localparam int unsigned LSIZE_W  = 64;

    localparam logic [TYPE_W-1:0] TYPE_MOOV = 32'h6D6F_6F76;
    localparam logic [TYPE_W-1:0] TYPE_FREE = 32'h6672_6565;

    // Header byte counts: size field ends, short header ends, long header ends
    localparam logic [HLEN_W-1:0] SIZE_END  = 5'd4;
    localparam logic [HLEN_W-1:0] HDR_SHORT = 5'd8;
    localparam logic [HLEN_W-1:0] HDR_LONG  = 5'd16;

    localparam logic [TYPE_W-1:0] SIZE_LARGE = 32'd1;
    localparam logic [TYPE_W-1:0] SIZE_TO_END = 32'd0;

    typedef struct packed {
        logic              header_valid;
        logic [POS_W-1:0]  box_offset;
        logic [POS_W-1:0]  box_size;
        logic [HLEN_W-1:0] header_length;
        logic [TYPE_W-1:0] box_type;
        logic              is_moov;
        logic              free_after_moov;
        logic              malformed;
        logic              walk_done;
        logic              moov_found;
        logic              moov_at_end;
    } t_result;

endpackage

FILE: rtl/mbhw_byte_if.sv
interface mbhw_byte_if;
    import mbhw_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

FILE: rtl/mbhw_result_if.sv
interface mbhw_result_if;
    import mbhw_pkg::*;

    logic              valid;
    logic              ready;
    logic              header_valid;
    logic [POS_W-1:0]  box_offset;
    logic [POS_W-1:0]  box_size;
    logic [HLEN_W-1:0] header_length;
    logic [TYPE_W-1:0] box_type;
    logic              is_moov;
    logic              free_after_moov;
    logic              malformed;
    logic              walk_done;
    logic              moov_found;
    logic              moov_at_end;

    modport source (
        output valid, input ready,
        output header_valid, box_offset, box_size, header_length, box_type,
        output is_moov, free_after_moov, malformed, walk_done, moov_found, moov_at_end
    );
    modport sink (
        input valid, output ready,
        input header_valid, box_offset, box_size, header_length, box_type,
        input is_moov, free_after_moov, malformed, walk_done, moov_found, moov_at_end
    );
endinterface

FILE: rtl/mbhw_core.sv
module mbhw_core #(
    parameter int unsigned OFFSET_BITS = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mbhw_pkg::POS_W-1:0]  i_cfg_wdata,
    input  logic                        i_valid,
    input  logic [mbhw_pkg::BYTE_W-1:0] i_byte,
    output logic                        o_ready,
    input  logic                        i_space,
    output logic                        o_push,
    output mbhw_pkg::t_result           o_result
);
    import mbhw_pkg::*;

    localparam int unsigned OB = OFFSET_BITS;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              fire;

    // walker state
    logic [OB-1:0]      r_len,       n_len;
    logic [OB-1:0]      r_pos,       n_pos;
    logic [HLEN_W-1:0]  r_hbc,       n_hbc;
    logic [TYPE_W-1:0]  r_size,      n_size;
    logic [TYPE_W-1:0]  r_type,      n_type;
    logic [LSIZE_W-1:0] r_large,     n_large;
    logic [OB-1:0]      r_start,     n_start;
    logic [OB-1:0]      r_skip,      n_skip;
    logic               r_moov_seen, n_moov_seen;
    logic [OB-1:0]      r_moov_end,  n_moov_end;
    logic               r_stopped,   n_stopped;
    logic               r_error,     n_error;

    // header capture
    logic               hdr_first;
    logic [OB-1:0]      hdr_start;
    logic [TYPE_W-1:0]  base_size, base_type, cap_size, cap_type;
    logic [LSIZE_W-1:0] base_large, cap_large;
    logic [HLEN_W-1:0]  hbc_inc;
    logic               done_short, done_long, hdr_done;
    logic [HLEN_W-1:0]  hlen;
    logic [OB-1:0]      left;
    logic               start_bad;
    logic [LSIZE_W-1:0] size_sel;
    logic               size_bad;
    logic               free_hit;
    logic               moov_hit;
    logic               emit;
    t_result            res;

    assign fire    = r_in_valid && i_space;
    assign o_ready = !r_in_valid || i_space;

    assign hdr_first  = (r_hbc == '0);
    assign hdr_start  = hdr_first ? r_pos : r_start;
    assign base_size  = hdr_first ? '0 : r_size;
    assign base_type  = hdr_first ? '0 : r_type;
    assign base_large = hdr_first ? '0 : r_large;
    assign cap_size   = (r_hbc < SIZE_END) ? {base_size[TYPE_W-BYTE_W-1:0], r_in_byte}
                                           : base_size;
    assign cap_type   = (r_hbc >= SIZE_END && r_hbc < HDR_SHORT)
                        ? {base_type[TYPE_W-BYTE_W-1:0], r_in_byte} : base_type;
    assign cap_large  = (r_hbc >= HDR_SHORT) ? {base_large[LSIZE_W-BYTE_W-1:0], r_in_byte}
                                             : base_large;
    assign hbc_inc    = r_hbc + HLEN_W'(1);
    assign done_short = (hbc_inc == HDR_SHORT) && (cap_size != SIZE_LARGE);
    assign done_long  = (hbc_inc >= HDR_LONG);
    assign hdr_done   = done_short || done_long;
    assign hlen       = done_long ? HDR_LONG : HDR_SHORT;
    assign left       = r_len - hdr_start;
    assign start_bad  = (r_len < hdr_start);
    assign size_sel   = done_long ? cap_large
                      : ((cap_size == SIZE_TO_END) ? LSIZE_W'(left) : LSIZE_W'(cap_size));
    assign size_bad   = (size_sel < LSIZE_W'(hlen)) || (size_sel > LSIZE_W'(left));
    assign free_hit   = (cap_type == TYPE_FREE) && r_moov_seen && (hdr_start == r_moov_end);
    assign moov_hit   = (cap_type == TYPE_MOOV);

    always_comb begin
        n_len       = i_cfg_we ? OB'(i_cfg_wdata) : r_len;
        n_pos       = r_pos;
        n_hbc       = r_hbc;
        n_size      = r_size;
        n_type      = r_type;
        n_large     = r_large;
        n_start     = r_start;
        n_skip      = r_skip;
        n_moov_seen = r_moov_seen;
        n_moov_end  = r_moov_end;
        n_stopped   = r_stopped;
        n_error     = r_error;
        emit        = 1'b0;
        res         = '0;

        if (fire && !r_stopped) begin
            if (r_pos >= r_len) begin
                // past the limit: byte dropped without being walked, walk ends
                n_error   = r_error || (r_hbc != '0) || (r_skip != '0);
                n_stopped = 1'b1;
                emit      = 1'b1;
            end else begin
                if (r_skip != '0) begin
                    n_skip = r_skip - OB'(1);
                end else begin
                    n_start = hdr_start;
                    n_size  = cap_size;
                    n_type  = cap_type;
                    n_large = cap_large;
                    n_hbc   = hbc_inc;
                    if (hdr_done) begin
                        n_hbc = '0;
                        emit  = 1'b1;
                        if (start_bad || size_bad) begin
                            n_error   = 1'b1;
                            n_stopped = 1'b1;
                        end else begin
                            res.header_valid  = 1'b1;
                            res.box_offset    = POS_W'(hdr_start);
                            res.box_size      = POS_W'(size_sel);
                            res.header_length = hlen;
                            res.box_type      = cap_type;
                            if (free_hit) begin
                                res.free_after_moov = 1'b1;
                                n_stopped           = 1'b1;
                            end else begin
                                if (moov_hit) begin
                                    res.is_moov = 1'b1;
                                    n_moov_seen = 1'b1;
                                    n_moov_end  = hdr_start + OB'(size_sel);
                                end
                                n_skip = OB'(size_sel - LSIZE_W'(hlen));
                            end
                        end
                    end
                end
                n_pos = r_pos + OB'(1);
                if (!n_stopped && n_pos >= r_len) begin
                    n_error   = n_error || (n_hbc != '0) || (n_skip != '0);
                    n_stopped = 1'b1;
                    emit      = 1'b1;
                end
            end
        end

        res.malformed   = n_error;
        res.walk_done   = n_stopped;
        res.moov_found  = n_moov_seen;
        res.moov_at_end = n_moov_seen && (n_moov_end == r_len);
    end

    assign o_push   = emit;
    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_len       <= '0;
            r_pos       <= '0;
            r_hbc       <= '0;
            r_size      <= '0;
            r_type      <= '0;
            r_large     <= '0;
            r_start     <= '0;
            r_skip      <= '0;
            r_moov_seen <= 1'b0;
            r_moov_end  <= '0;
            r_stopped   <= 1'b0;
            r_error     <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_hbc       <= n_hbc;
            r_size      <= n_size;
            r_type      <= n_type;
            r_large     <= n_large;
            r_start     <= n_start;
            r_skip      <= n_skip;
            r_moov_seen <= n_moov_seen;
            r_moov_end  <= n_moov_end;
            r_stopped   <= n_stopped;
            r_error     <= n_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_byte;
        end
    end

`ifndef NO_ASSERTIONS
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("walk restarted without reset");

    a_error_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error |-> r_stopped)
        else $error("malformed table did not stop the walk");

    a_hdr_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.header_valid) |->
        ((o_result.header_length == HDR_SHORT) || (o_result.header_length == HDR_LONG)))
        else $error("bad header length reported");

    a_free_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.free_after_moov) |=> r_stopped)
        else $error("free after moov did not end the walk");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_space)
        else $error("result pushed with no buffer space");
`endif
endmodule

FILE: rtl/mbhw_out_buf.sv
module mbhw_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mbhw_pkg::t_result i_result,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output mbhw_pkg::t_result o_result
);
    import mbhw_pkg::*;

    t_result    r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic       pop;

    assign o_space  = (r_count != 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_result = r_slot[r_rp];
    assign pop      = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_result;
        end
    end
endmodule

FILE: rtl/mp4_box_header_walker_top.sv
// MP4 top-level box walker.
// i_data carries the stream one byte per transaction, in file order. o_result
// carries a transaction for every completed box header, for a malformed header
// and for the end of the walk, with moov/free flags and sticky status bits.
// Write the stream length through i_cfg_we / i_cfg_wdata while the block is
// idle; it bounds the walk.
// A byte taken lands in the input register, is walked from there into the
// two-entry result buffer, and its result is then offered from that
// buffer.
// Throughput: one byte per cycle while the result buffer has space; the
// walker update (header capture, size checks and skip count) is one pass.
// Reset (synchronous, active low) clears the walker: position, header
// capture, skip count, moov tracking, status, and the stream length.
// When the receiver stalls, the result buffer absorbs up to two results;
// i_data.ready drops only once the buffer is full and the input register
// holds a byte that cannot be walked yet. No transaction is lost.
// After the walk stops, bytes are still taken but produce no results.
module mp4_box_header_walker_top #(
    parameter int unsigned OFFSET_BITS = 48
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [mbhw_pkg::POS_W-1:0] i_cfg_wdata,
    mbhw_byte_if.sink                  i_data,
    mbhw_result_if.source              o_result
);
    import mbhw_pkg::*;

    logic    push;
    logic    space;
    t_result core_res;
    t_result buf_res;

    // walker: input register plus single-pass header/skip logic
    mbhw_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_data.valid),
        .i_byte      (i_data.data_byte),
        .o_ready     (i_data.ready),
        .i_space     (space),
        .o_push      (push),
        .o_result    (core_res)
    );

    // result register with a skid entry
    mbhw_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (core_res),
        .o_space  (space),
        .o_valid  (o_result.valid),
        .i_ready  (o_result.ready),
        .o_result (buf_res)
    );

    // unpack result fields onto the channel
    assign o_result.header_valid    = buf_res.header_valid;
    assign o_result.box_offset      = buf_res.box_offset;
    assign o_result.box_size        = buf_res.box_size;
    assign o_result.header_length   = buf_res.header_length;
    assign o_result.box_type        = buf_res.box_type;
    assign o_result.is_moov         = buf_res.is_moov;
    assign o_result.free_after_moov = buf_res.free_after_moov;
    assign o_result.malformed       = buf_res.malformed;
    assign o_result.walk_done       = buf_res.walk_done;
    assign o_result.moov_found      = buf_res.moov_found;
    assign o_result.moov_at_end     = buf_res.moov_at_end;
endmodule
